/* rtl/soc_lfh_pkg.sv */
`default_nettype none

package soc_lfh_pkg;

   // Field widths
   localparam int VOLT_W      = 16;
   localparam int HYST_W      = 10;
   localparam int LEVEL_W     = 3;
   localparam int DBC_W       = 2;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 16;
   localparam int THR_REGS    = 5;
   localparam int LEVEL_SLOTS = 1 << LEVEL_W;

   typedef logic [VOLT_W-1:0]  volt_type;
   typedef logic [HYST_W-1:0]  hyst_type;
   typedef logic [LEVEL_W-1:0] level_type;

   // Request function codes
   localparam logic FUNC_ADD  = 1'b0;
   localparam logic FUNC_INIT = 1'b1;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_THR_L1    = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_L2    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_L3    = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_L4    = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_THR_L5    = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_HALF_HYST = 3'd5;

   // Register reset values
   localparam volt_type THR_RESET_L1 = 16'd4620;
   localparam volt_type THR_RESET_L2 = 16'd4970;
   localparam volt_type THR_RESET_L3 = 16'd5180;
   localparam volt_type THR_RESET_L4 = 16'd5390;
   localparam volt_type THR_RESET_L5 = 16'd5600;
   localparam hyst_type HYST_RESET   = 10'd14;

   // Threshold of levels that have no register
   localparam volt_type THR_MAX = 16'hFFFF;

   typedef struct packed {
      logic     func;
      volt_type pack_volt;
   } req_type;

   typedef struct packed {
      level_type level;
      level_type instant_level;
      logic      level_changed;
   } rsp_type;

endpackage

`default_nettype wire

/* rtl/soc_level_filter_hysteresis_unit.sv */
// Charge-level filter: moving average of pack-voltage samples, quantized to a
// level with hysteresis and debounce.
// Request channel (req_valid / req_stall / req_data): func selects add-sample
// or initialize-window; pack_volt is in 10 mV units. A request is taken
// on an edge with req_valid high and req_stall low.
// Response channel (rsp_valid / rsp_stall / rsp_data): exactly one response
// per request, in order: committed level, instant level, level-changed flag.
// Register port (csr_valid / csr_ready / csr_index / csr_data): csr_ready is
// always high; indexes 0..4 are the level thresholds, 5 the half hysteresis,
// others are ignored. Write registers only while no request is in flight.
// A taken request passes the stage-1, stage-2 and response registers before
// its response is visible. Throughput: one request per cycle, sustained while
// rsp_stall is low. The window lives in a RAM with a registered read; the
// running sum updates in stage 1 and the level decision in stage 2, each once per cycle while not stalled.
// Reset (synchronous): window empty, level 0, no candidate, registers at their
// defaults. No clearing pass is needed.
// A stalled response holds in the output register while the next request is
// still taken; the pipe fills and req_stall rises only when all stages hold.
`default_nettype none

module soc_level_filter_hysteresis_unit #(
   parameter int WINDOW_DEPTH   = 5,
   parameter int LEVEL_COUNT    = 5,
   parameter int DEBOUNCE_LIMIT = 3
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    req_valid,
   output logic                                    req_stall,
   input  soc_lfh_pkg::req_type                    req_data,
   output logic                                    rsp_valid,
   input  logic                                    rsp_stall,
   output soc_lfh_pkg::rsp_type                    rsp_data,
   input  logic                                    csr_valid,
   output logic                                    csr_ready,
   input  logic [soc_lfh_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [soc_lfh_pkg::CSR_DATA_W-1:0]      csr_data
);

   import soc_lfh_pkg::*;

   localparam int LEVEL_TOP = (LEVEL_COUNT > 7) ? 7 : LEVEL_COUNT;
   localparam int IDX_W     = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
   localparam int CNT_W     = $clog2(WINDOW_DEPTH + 1);
   localparam int SUM_W     = $clog2(WINDOW_DEPTH * ((1 << VOLT_W) - 1) + 1);
   localparam int PROD_W    = CNT_W + VOLT_W;
   localparam int HCNT_W    = CNT_W + HYST_W;
   localparam int CMP_W     = PROD_W + 1;

   localparam logic [IDX_W-1:0] IDX_LAST  = IDX_W'(WINDOW_DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL  = CNT_W'(WINDOW_DEPTH);
   localparam logic [CNT_W-1:0] CNT_ONE   = CNT_W'(1);
   localparam logic [DBC_W-1:0] DBC_LIMIT = DBC_W'(DEBOUNCE_LIMIT);
   localparam logic [DBC_W-1:0] DBC_ONE   = DBC_W'(1);

   // Configuration registers
   volt_type thr_ff [THR_REGS];
   hyst_type hyst_ff;
   volt_type thr_slot [LEVEL_SLOTS];

   // Window bookkeeping
   logic [CNT_W-1:0] fill_ff;
   logic [CNT_W-1:0] fill_in;
   logic [IDX_W-1:0] wr_idx_ff;
   logic             since_init_ff;
   volt_type         init_val_ff;
   logic [SUM_W-1:0] sum_ff;
   logic [SUM_W-1:0] sum_in;

   // Stage 0
   logic             acc;
   logic             is_init0;
   logic             evict0;
   logic [CNT_W-1:0] cnt0;

   // Stage 1: RAM data returns, running sum updates
   logic              s1_valid_ff;
   logic              s1_init_ff;
   logic              s1_evict_ff;
   logic              s1_use_init_ff;
   volt_type          s1_init_val_ff;
   logic [IDX_W-1:0]  s1_addr_ff;
   volt_type          s1_v_ff;
   logic [PROD_W-1:0] s1_prod_ff [LEVEL_SLOTS];
   logic [HCNT_W-1:0] s1_hcnt_ff;
   logic              fwd_ff;
   logic              fwd_in;
   volt_type          fwd_data_ff;
   volt_type          ram_rd_data;
   volt_type          old1;
   logic [SUM_W-1:0]  cmp_sum1;
   logic              mv1;

   // Stage 2: quantize and debounce
   logic              s2_valid_ff;
   logic              s2_init_ff;
   logic [SUM_W-1:0]  s2_sum_ff;
   logic [PROD_W-1:0] s2_prod_ff [LEVEL_SLOTS];
   logic [HCNT_W-1:0] s2_hcnt_ff;
   level_type         raw_in;
   level_type         raw_up;
   logic              rise_ok;
   logic              fall_ok;
   logic              mv2;

   // Level state
   level_type         level_ff;
   level_type         level_in;
   logic              cand_valid_ff;
   logic              cand_valid_in;
   level_type         cand_level_ff;
   level_type         cand_level_in;
   logic [DBC_W-1:0]  cand_hits_ff;
   logic [DBC_W-1:0]  cand_hits_in;
   logic              changed_in;

   // Response register
   logic              rsp_valid_ff;
   rsp_type           rsp_data_ff;
   logic              out_ready;

   // Register writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff[0] <= THR_RESET_L1;
         thr_ff[1] <= THR_RESET_L2;
         thr_ff[2] <= THR_RESET_L3;
         thr_ff[3] <= THR_RESET_L4;
         thr_ff[4] <= THR_RESET_L5;
         hyst_ff   <= HYST_RESET;
      end else if (csr_valid && csr_ready) begin
         case (csr_index)
            CSR_HALF_HYST: hyst_ff <= csr_data[HYST_W-1:0];
            default: begin
               if (csr_index inside {[CSR_THR_L1:CSR_THR_L5]}) begin
                  thr_ff[csr_index] <= csr_data;
               end
            end
         endcase
      end
   end

   // Threshold of each level slot; slot 0 is unused
   for (genvar k = 0; k < LEVEL_SLOTS; k++) begin : g_thr
      if (k == 0) begin : g_zero
         assign thr_slot[k] = '0;
      end else if (k <= THR_REGS) begin : g_reg
         assign thr_slot[k] = thr_ff[k-1];
      end else begin : g_max
         assign thr_slot[k] = THR_MAX;
      end
   end

   // Handshake across the pipe
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign mv2       = s2_valid_ff && out_ready;
   assign mv1       = s1_valid_ff && (!s2_valid_ff || mv2);
   assign req_stall = s1_valid_ff && !mv1;
   assign acc       = req_valid && !req_stall;

   // Stage 0: advance window pointers, precompute count-scaled thresholds
   assign is_init0 = (req_data.func == FUNC_INIT);
   assign evict0   = (fill_ff == CNT_FULL);
   assign fill_in  = evict0 ? fill_ff : fill_ff + CNT_ONE;
   assign cnt0     = is_init0 ? CNT_ONE : fill_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff       <= '0;
         wr_idx_ff     <= '0;
         since_init_ff <= 1'b0;
      end else if (acc) begin
         if (is_init0) begin
            fill_ff       <= CNT_FULL;
            wr_idx_ff     <= '0;
            since_init_ff <= 1'b1;
         end else begin
            fill_ff <= fill_in;
            if (wr_idx_ff == IDX_LAST) begin
               wr_idx_ff     <= '0;
               since_init_ff <= 1'b0;
            end else begin
               wr_idx_ff <= wr_idx_ff + IDX_W'(1);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (acc && is_init0) begin
         init_val_ff <= req_data.pack_volt;
      end
   end

   // Forward the value written this edge when it is the entry being read
   assign fwd_in = mv1 && !s1_init_ff && (s1_addr_ff == wr_idx_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (acc) begin
         s1_valid_ff <= 1'b1;
      end else if (mv1) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (acc) begin
         s1_init_ff     <= is_init0;
         s1_evict_ff    <= evict0;
         s1_use_init_ff <= since_init_ff;
         s1_init_val_ff <= init_val_ff;
         s1_addr_ff     <= wr_idx_ff;
         s1_v_ff        <= req_data.pack_volt;
         s1_hcnt_ff     <= HCNT_W'(cnt0) * HCNT_W'(hyst_ff);
         fwd_ff         <= fwd_in;
         fwd_data_ff    <= s1_v_ff;
         for (int k = 0; k < LEVEL_SLOTS; k++) begin
            s1_prod_ff[k] <= PROD_W'(cnt0) * PROD_W'(thr_slot[k]);
         end
      end
   end

   soc_lfh_ram #(
      .WIDTH (VOLT_W),
      .DEPTH (WINDOW_DEPTH)
   ) u_window_ram (
      .clock   (clock),
      .wr_en   (mv1 && !s1_init_ff),
      .wr_addr (s1_addr_ff),
      .wr_data (s1_v_ff),
      .rd_en   (acc && !is_init0),
      .rd_addr (wr_idx_ff),
      .rd_data (ram_rd_data)
   );

   // Stage 1: pick the evicted sample, update the running sum
   always_comb begin
      if (s1_use_init_ff) begin
         old1 = s1_init_val_ff;
      end else if (fwd_ff) begin
         old1 = fwd_data_ff;
      end else begin
         old1 = ram_rd_data;
      end

      if (s1_init_ff) begin
         sum_in   = SUM_W'(s1_v_ff) * SUM_W'(WINDOW_DEPTH);
         cmp_sum1 = SUM_W'(s1_v_ff);
      end else begin
         if (s1_evict_ff) begin
            sum_in = sum_ff - SUM_W'(old1) + SUM_W'(s1_v_ff);
         end else begin
            sum_in = sum_ff + SUM_W'(s1_v_ff);
         end
         cmp_sum1 = sum_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         sum_ff      <= '0;
         s2_valid_ff <= 1'b0;
      end else begin
         if (mv1) begin
            sum_ff      <= sum_in;
            s2_valid_ff <= 1'b1;
         end else if (mv2) begin
            s2_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mv1) begin
         s2_init_ff <= s1_init_ff;
         s2_sum_ff  <= cmp_sum1;
         s2_hcnt_ff <= s1_hcnt_ff;
         for (int k = 0; k < LEVEL_SLOTS; k++) begin
            s2_prod_ff[k] <= s1_prod_ff[k];
         end
      end
   end

   // Stage 2: quantize the average, check margins
   always_comb begin
      raw_in = '0;
      for (int k = 1; k <= LEVEL_TOP; k++) begin
         if (CMP_W'(s2_sum_ff) >= CMP_W'(s2_prod_ff[LEVEL_W'(k)])) begin
            raw_in = LEVEL_W'(k);
         end
      end
      raw_up  = raw_in + LEVEL_W'(1);
      rise_ok = CMP_W'(s2_sum_ff) >= CMP_W'(s2_prod_ff[raw_in]) + CMP_W'(s2_hcnt_ff);
      fall_ok = CMP_W'(s2_sum_ff) + CMP_W'(s2_hcnt_ff) <= CMP_W'(s2_prod_ff[raw_up]);
   end

   // Debounce: track candidate, commit after enough agreeing requests
   always_comb begin
      level_in      = level_ff;
      cand_valid_in = cand_valid_ff;
      cand_level_in = cand_level_ff;
      cand_hits_in  = cand_hits_ff;
      changed_in    = 1'b0;

      if (s2_init_ff) begin
         level_in      = raw_in;
         cand_valid_in = 1'b0;
         cand_level_in = '0;
         cand_hits_in  = '0;
         changed_in    = (raw_in != level_ff);
      end else if (raw_in == level_ff) begin
         cand_valid_in = 1'b0;
         cand_level_in = '0;
         cand_hits_in  = '0;
      end else if (!cand_valid_ff || (cand_level_ff != raw_in)) begin
         cand_valid_in = 1'b1;
         cand_level_in = raw_in;
         cand_hits_in  = DBC_ONE;
      end else if ((raw_in > level_ff) ? rise_ok : fall_ok) begin
         if (cand_hits_ff + DBC_ONE >= DBC_LIMIT) begin
            level_in      = cand_level_ff;
            cand_valid_in = 1'b0;
            cand_level_in = '0;
            cand_hits_in  = '0;
            changed_in    = 1'b1;
         end else begin
            cand_hits_in = cand_hits_ff + DBC_ONE;
         end
      end else begin
         // margin failed: keep the candidate, restart its count
         cand_hits_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff      <= '0;
         cand_valid_ff <= 1'b0;
         cand_level_ff <= '0;
         cand_hits_ff  <= '0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (mv2) begin
            level_ff      <= level_in;
            cand_valid_ff <= cand_valid_in;
            cand_level_ff <= cand_level_in;
            cand_hits_ff  <= cand_hits_in;
            rsp_valid_ff  <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (mv2) begin
         rsp_data_ff.level         <= level_in;
         rsp_data_ff.instant_level <= raw_in;
         rsp_data_ff.level_changed <= changed_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

/* rtl/soc_lfh_ram.sv */
`default_nettype none

module soc_lfh_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 5
) (
   input  logic                                        clock,
   input  logic                                        wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  logic [WIDTH-1:0]                            wr_data,
   input  logic                                        rd_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic [WIDTH-1:0]                            rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // Registered read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem_ff[rd_addr];
      end
   end

endmodule

`default_nettype wire

/* rtl/soc_lfh_checker.sv */
`default_nettype none

module soc_lfh_checker #(
   parameter int LEVEL_COUNT = 5
) (
   input logic                 clock,
   input logic                 reset,
   input logic                 rsp_valid,
   input logic                 rsp_stall,
   input soc_lfh_pkg::rsp_type rsp_data
);

   import soc_lfh_pkg::*;

   localparam int        LEVEL_TOP = (LEVEL_COUNT > 7) ? 7 : LEVEL_COUNT;
   localparam level_type LEVEL_MAX = LEVEL_W'(LEVEL_TOP);

   logic      rsp_fire;
   level_type prev_level_ff;

   assign rsp_fire = rsp_valid && !rsp_stall;

   // Track the last delivered committed level
   always_ff @(posedge clock) begin
      if (reset) begin
         prev_level_ff <= '0;
      end else if (rsp_fire) begin
         prev_level_ff <= rsp_data.level;
      end
   end

   // No response in the cycle after reset
   a_reset_idle: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid right after reset");

   // A stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response changed");

   // Levels stay in range
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.level <= LEVEL_MAX) && (rsp_data.instant_level <= LEVEL_MAX))
      else $error("level out of range");

   // Change flag matches a change of the committed level between responses
   a_changed_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_fire |-> (rsp_data.level_changed == (rsp_data.level != prev_level_ff)))
      else $error("level_changed does not match committed level");

endmodule

bind soc_level_filter_hysteresis_unit soc_lfh_checker #(
   .LEVEL_COUNT (LEVEL_COUNT)
) u_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

`default_nettype wire
